// ----- hdl/rcpwd_pkg.sv -----
package rcpwd_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int TIMER_BITS_MIN = 8;
  localparam int TIMER_BITS_MAX = 32;

  localparam int TVAL_W = 16;   // timer sample width on the port
  localparam int EDGE_W = 17;   // stored edge time, signed
  localparam int PW_W   = 18;   // measured pulse width, signed
  localparam int LIM_W  = 16;   // limit registers
  localparam int DB_W   = 7;    // speed deadband register
  localparam int SPD_W  = 8;    // speed limit
  localparam int NCHAN  = 4;

  localparam logic signed [EDGE_W-1:0] EDGE_RST = -17'sd1000;

  // configuration register indexes
  localparam logic [2:0] CFG_TIMER_TOP    = 3'd0;
  localparam logic [2:0] CFG_OVR_LOW      = 3'd1;
  localparam logic [2:0] CFG_FLAG_LOW     = 3'd2;
  localparam logic [2:0] CFG_FLAG_HIGH    = 3'd3;
  localparam logic [2:0] CFG_PULSE_LIMIT  = 3'd4;
  localparam logic [2:0] CFG_SPEED_OFFSET = 3'd5;
  localparam logic [2:0] CFG_SPEED_DB     = 3'd6;

  localparam logic [LIM_W-1:0] TIMER_TOP_RST    = 16'd65535;
  localparam logic [LIM_W-1:0] OVR_LOW_RST      = 16'd300;
  localparam logic [LIM_W-1:0] FLAG_LOW_RST     = 16'd270;
  localparam logic [LIM_W-1:0] FLAG_HIGH_RST    = 16'd410;
  localparam logic [LIM_W-1:0] PULSE_LIMIT_RST  = 16'd650;
  localparam logic [LIM_W-1:0] SPEED_OFFSET_RST = 16'd100;
  localparam logic [DB_W-1:0]  SPEED_DB_RST     = 7'd4;

  typedef struct packed {
    logic [NCHAN-1:0]  pin_levels;
    logic [TVAL_W-1:0] timer_value;
  } in_beat_t;

  typedef struct packed {
    logic                    override_mode;
    logic                    extra_mode;
    logic                    obstacle_ignore;
    logic signed [SPD_W-1:0] speed_limit;
  } out_beat_t;

  // falling-edge event from one channel tracker
  typedef struct packed {
    logic                   fall;
    logic signed [PW_W-1:0] width;
  } chan_evt_t;

  // width compared against an unsigned limit
  function automatic logic pw_lt(logic signed [PW_W-1:0] w, logic [LIM_W-1:0] lim);
    pw_lt = w < $signed({2'b00, lim});
  endfunction

  function automatic logic pw_gt(logic signed [PW_W-1:0] w, logic [LIM_W-1:0] lim);
    pw_gt = w > $signed({2'b00, lim});
  endfunction

endpackage

// ----- hdl/rc_pulse_width_decoder.sv -----
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   in_data   (pin_levels, timer_value)
// out      output     out_valid / out_ready out_data  (flags, speed_limit)
// cfg      input      cfg_we                cfg_index, cfg_wdata
//
// one beat per cycle sustained while out_ready holds; a beat passes through the input
// register and then the result register, which drives out (two-register pass)
// the channel state updates as the beat moves from the input register into
// the result register, so the following beat already sees it
// synchronous active-low reset clears the channel state, the config registers and both valid flags
// a stalled out holds its beat while one more beat waits in the input register
module rc_pulse_width_decoder #(
  parameter int TIMER_BITS = rcpwd_pkg::TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rcpwd_pkg::in_beat_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rcpwd_pkg::out_beat_t  out_data,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_wdata
);
  import rcpwd_pkg::*;

  // configuration registers
  logic [LIM_W-1:0] timer_top_r;
  logic [LIM_W-1:0] ovr_low_r;
  logic [LIM_W-1:0] flag_low_r;
  logic [LIM_W-1:0] flag_high_r;
  logic [LIM_W-1:0] pulse_limit_r;
  logic [LIM_W-1:0] speed_offset_r;
  logic [DB_W-1:0]  speed_db_r;

  // input and result registers
  logic       s1_valid_r;
  in_beat_t   s1_data_r;
  logic       out_valid_r;
  out_beat_t  out_data_r;
  logic       step;

  // decoded mode flags
  logic ovr_r, ovr_nxt;
  logic extra_r, extra_nxt;
  logic obst_r, obst_nxt;

  logic [TVAL_W-1:0] tmask;
  logic [TVAL_W-1:0] now;
  chan_evt_t         evt [NCHAN];
  logic [NCHAN-1:0]  chan_en;
  logic signed [SPD_W-1:0] speed_nxt;
  logic signed [SPD_W-1:0] speed_r;

  // timer sample is cut down to the timer width
  for (genvar i = 0; i < TVAL_W; i++) begin : g_mask
    assign tmask[i] = (i < TIMER_BITS);
  end
  assign now = s1_data_r.timer_value & tmask;

  // beat moves on when the result slot is free or being drained
  assign step     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_top_r    <= TIMER_TOP_RST;
      ovr_low_r      <= OVR_LOW_RST;
      flag_low_r     <= FLAG_LOW_RST;
      flag_high_r    <= FLAG_HIGH_RST;
      pulse_limit_r  <= PULSE_LIMIT_RST;
      speed_offset_r <= SPEED_OFFSET_RST;
      speed_db_r     <= SPEED_DB_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMER_TOP:    timer_top_r    <= cfg_wdata;
        CFG_OVR_LOW:      ovr_low_r      <= cfg_wdata;
        CFG_FLAG_LOW:     flag_low_r     <= cfg_wdata;
        CFG_FLAG_HIGH:    flag_high_r    <= cfg_wdata;
        CFG_PULSE_LIMIT:  pulse_limit_r  <= cfg_wdata;
        CFG_SPEED_OFFSET: speed_offset_r <= cfg_wdata;
        CFG_SPEED_DB:     speed_db_r     <= cfg_wdata[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // channels two and three only track while override is on after channel zero
  assign chan_en = {ovr_nxt, ovr_nxt, 1'b1, 1'b1};

  for (genvar c = 0; c < NCHAN; c++) begin : g_chan
    rcpwd_chan u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (step),
      .en        (chan_en[c]),
      .lvl       (s1_data_r.pin_levels[c]),
      .now       (now),
      .timer_top (timer_top_r),
      .evt       (evt[c])
    );
  end

  always_comb begin
    ovr_nxt = ovr_r;
    if (evt[0].fall) begin
      if (pw_lt(evt[0].width, ovr_low_r)) begin
        ovr_nxt = 1'b0;
      end else if (pw_lt(evt[0].width, pulse_limit_r)) begin
        ovr_nxt = 1'b1;
      end
    end
  end

  // extra and obstacle flags, each with a dead zone between the low and high limits
  always_comb begin
    extra_nxt = extra_r;
    if (evt[1].fall) begin
      if (pw_lt(evt[1].width, flag_low_r)) begin
        extra_nxt = 1'b0;
      end else if (pw_gt(evt[1].width, flag_high_r)
                   && pw_lt(evt[1].width, pulse_limit_r)) begin
        extra_nxt = 1'b1;
      end
    end
    obst_nxt = obst_r;
    if (evt[2].fall) begin
      if (pw_lt(evt[2].width, flag_low_r)) begin
        obst_nxt = 1'b0;
      end else if (pw_gt(evt[2].width, flag_high_r)
                   && pw_lt(evt[2].width, pulse_limit_r)) begin
        obst_nxt = 1'b1;
      end
    end
  end

  rcpwd_speed u_speed (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .evt          (evt[3]),
    .pulse_limit  (pulse_limit_r),
    .speed_offset (speed_offset_r),
    .speed_db     (speed_db_r),
    .speed_nxt    (speed_nxt),
    .speed_r      (speed_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovr_r   <= 1'b0;
      extra_r <= 1'b0;
      obst_r  <= 1'b0;
    end else if (step) begin
      ovr_r   <= ovr_nxt;
      extra_r <= extra_nxt;
      obst_r  <= obst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r.override_mode   <= ovr_nxt;
      out_data_r.extra_mode      <= extra_nxt;
      out_data_r.obstacle_ignore <= obst_nxt;
      out_data_r.speed_limit     <= speed_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // both registers full and out stalled: no room for another beat
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted with both stages full");

  // speed only moves while override is on
  a_speed_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ovr_nxt |=> $stable(speed_r))
    else $error("speed changed with override off");

  // drained result with nothing behind it leaves out empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !s1_valid_r |=> !out_valid_r)
    else $error("result repeated after drain");
`endif

endmodule

// ----- hdl/rcpwd_chan.sv -----
module rcpwd_chan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       en,
  input  logic                       lvl,
  input  logic [rcpwd_pkg::TVAL_W-1:0] now,
  input  logic [rcpwd_pkg::LIM_W-1:0]  timer_top,
  output rcpwd_pkg::chan_evt_t       evt
);
  import rcpwd_pkg::*;

  logic                     prev_r;
  logic signed [EDGE_W-1:0] edge_r;
  logic                     chg;
  logic signed [PW_W-1:0]   now_s;
  logic signed [PW_W-1:0]   last_s;
  logic signed [PW_W-1:0]   top_s;

  assign chg    = en && (lvl != prev_r);
  assign now_s  = $signed({2'b00, now});
  assign last_s = PW_W'(edge_r);
  assign top_s  = $signed({2'b00, timer_top});

  always_comb begin
    evt.fall = chg && !lvl;
    // timer wrapped since the last change
    if (now_s < last_s) begin
      evt.width = now_s + top_s - last_s;
    end else begin
      evt.width = now_s - last_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      edge_r <= EDGE_RST;
    end else if (step && chg) begin
      prev_r <= lvl;
      edge_r <= $signed({1'b0, now});
    end
  end

endmodule

// ----- hdl/rcpwd_speed.sv -----
module rcpwd_speed (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  rcpwd_pkg::chan_evt_t              evt,
  input  logic [rcpwd_pkg::LIM_W-1:0]       pulse_limit,
  input  logic [rcpwd_pkg::LIM_W-1:0]       speed_offset,
  input  logic [rcpwd_pkg::DB_W-1:0]        speed_db,
  output logic signed [rcpwd_pkg::SPD_W-1:0] speed_nxt,
  output logic signed [rcpwd_pkg::SPD_W-1:0] speed_r
);
  import rcpwd_pkg::*;

  localparam int DIF_W = PW_W + 1;
  localparam int CND_W = DIF_W - 3;

  logic signed [DIF_W-1:0] dif;
  logic signed [DIF_W-1:0] dif_adj;
  logic signed [CND_W-1:0] cand;
  logic signed [CND_W:0]   spd_diff;
  logic        [CND_W:0]   spd_diff_abs;
  logic                    take;
  logic signed [SPD_W-1:0] sat;

  assign dif = DIF_W'(evt.width) - $signed({3'b000, speed_offset});
  // bias negatives so the shift truncates toward zero
  assign dif_adj      = dif + $signed({{(DIF_W-3){1'b0}}, {3{dif[DIF_W-1]}}});
  assign cand         = dif_adj[DIF_W-1:3];
  assign spd_diff     = (CND_W+1)'(cand) - (CND_W+1)'(speed_r);
  assign spd_diff_abs = spd_diff[CND_W] ? unsigned'(-spd_diff) : unsigned'(spd_diff);
  assign take         = evt.fall && pw_lt(evt.width, pulse_limit)
                        && (spd_diff_abs > {{(CND_W+1-DB_W){1'b0}}, speed_db});

  always_comb begin
    if (cand > CND_W'(127)) begin
      sat = 8'sd127;
    end else if (cand < -CND_W'(128)) begin
      sat = -8'sd128;
    end else begin
      sat = cand[SPD_W-1:0];
    end
    speed_nxt = take ? sat : speed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
    end else if (step) begin
      speed_r <= speed_nxt;
    end
  end

endmodule
